[rtl/sit_pkg.sv]
// Shared constants and types for the segment intersection test.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sit_pkg;

  localparam int unsigned CoordBitsDef = 24;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    CFG_LOCAL_START_X = 3'd0,
    CFG_LOCAL_START_Y = 3'd1,
    CFG_LOCAL_END_X   = 3'd2,
    CFG_LOCAL_END_Y   = 3'd3,
    CFG_ORIGIN_X      = 3'd4,
    CFG_ORIGIN_Y      = 3'd5,
    CFG_MIRROR        = 3'd6
  } cfg_idx_e;

endpackage
`default_nettype wire

[rtl/sit_muldiv.sv]
// Pipelined round(a * b / c) for 0 <= b <= c, one bit of a per stage.
// Depends on sit_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sit_muldiv import sit_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  wire                      clk_i,
  input  wire                      en_i,
  input  wire  [CoordBits:0]       mag_i,  // a, held static while items are in flight
  input  wire  [2*CoordBits+3:0]   b_i,
  input  wire  [2*CoordBits+3:0]   c_i,
  output logic [CoordBits+1:0]     q_o     // rounded quotient, ties up
);

  localparam int unsigned MW = CoordBits + 1;     // bits of a, one stage each
  localparam int unsigned UW = 2 * CoordBits + 4;

  logic [MW-1:0] q_q [MW];
  logic [UW-1:0] r_q [MW];
  logic [UW-1:0] b_q [MW];
  logic [UW-1:0] c_q [MW];

  for (genvar k = 0; k < MW; k++) begin : g_stage
    logic [MW-1:0] q_in, q_d;
    logic [UW-1:0] r_in, b_in, c_in;
    logic [UW:0]   r2;

    if (k == 0) begin : g_first
      assign q_in = '0;
      assign r_in = '0;
      assign b_in = b_i;
      assign c_in = c_i;
    end else begin : g_next
      assign q_in = q_q[k-1];
      assign r_in = r_q[k-1];
      assign b_in = b_q[k-1];
      assign c_in = c_q[k-1];
    end

    always_comb begin
      q_d = {q_in[MW-2:0], 1'b0};
      r2  = {r_in, 1'b0};
      if (r2 >= {1'b0, c_in}) begin
        r2  = r2 - {1'b0, c_in};
        q_d = q_d + MW'(1);
      end
      if (mag_i[MW-1-k]) begin
        r2 = r2 + {1'b0, b_in};
        if (r2 >= {1'b0, c_in}) begin
          r2  = r2 - {1'b0, c_in};
          q_d = q_d + MW'(1);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[k] <= q_d;
        r_q[k] <= r2[UW-1:0];
        b_q[k] <= b_in;
        c_q[k] <= c_in;
      end
    end
  end

  // round half up: r >= c - r
  assign q_o = {1'b0, q_q[MW-1]} +
               ((r_q[MW-1] >= (c_q[MW-1] - r_q[MW-1])) ? (MW+1)'(1) : (MW+1)'(0));

endmodule
`default_nettype wire

[rtl/segment_intersection_test.sv]
// Top level of the segment intersection test: config registers, cross
// products, hit decision and output register. Depends on sit_pkg, sit_muldiv.
`timescale 1ns / 1ps
`default_nettype none
// Tests each probe segment against one configured line segment and returns
// exactly one item per probe: hit, and on a hit the crossing point rounded to
// the nearest LSB (ties away from the line start) and saturated; zero otherwise.
// Parallel, collinear and zero-length cases never hit. A probe is taken every
// cycle while the master side does not stall. The pipeline has four arithmetic
// stages, one stage per magnitude bit of the line direction in the quotient
// pipeline and one output register. The whole pipeline advances together, so
// a stall on the master side holds every stage. Write the configuration only
// while no item is in flight.
module segment_intersection_test import sit_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire  [2:0]            cfg_idx_i,
  input  wire  [CoordBits-1:0]  cfg_data_i,
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  // probe_start_x, probe_start_y, probe_end_x, probe_end_y
  input  wire  [((4*CoordBits+7)/8)*8-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  // hit, cross_x, cross_y, zero padding
  output logic [((2*CoordBits+8)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned C   = CoordBits;
  localparam int unsigned MW  = C + 1;
  localparam int unsigned PW  = 2 * C + 4;   // products
  localparam int unsigned SW  = 2 * C + 5;   // cross-product sums
  localparam int unsigned UW  = 2 * C + 4;   // normalised magnitudes
  localparam int unsigned OW  = ((2*C+8)/8)*8;

  // ---------------- configuration
  logic signed [C-1:0] lsx_q, lsy_q, lex_q, ley_q, ox_q, oy_q;
  logic                mirror_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lsx_q <= '0; lsy_q <= '0; lex_q <= '0; ley_q <= '0;
      ox_q <= '0; oy_q <= '0; mirror_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOCAL_START_X: lsx_q <= cfg_data_i;
        CFG_LOCAL_START_Y: lsy_q <= cfg_data_i;
        CFG_LOCAL_END_X:   lex_q <= cfg_data_i;
        CFG_LOCAL_END_Y:   ley_q <= cfg_data_i;
        CFG_ORIGIN_X:      ox_q <= cfg_data_i;
        CFG_ORIGIN_Y:      oy_q <= cfg_data_i;
        CFG_MIRROR:        mirror_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // world end points of the line; the user must keep them static while items are in flight (not enforced)
  logic signed [C:0]   px, py, qx, qy;
  logic signed [C+1:0] dx, dy;
  logic [MW-1:0]       magx, magy;

  always_comb begin
    if (mirror_q) begin
      px = {ox_q[C-1], ox_q} - {lex_q[C-1], lex_q};
      py = {oy_q[C-1], oy_q} + {ley_q[C-1], ley_q};
      qx = {ox_q[C-1], ox_q} - {lsx_q[C-1], lsx_q};
      qy = {oy_q[C-1], oy_q} + {lsy_q[C-1], lsy_q};
    end else begin
      px = {ox_q[C-1], ox_q} + {lsx_q[C-1], lsx_q};
      py = {oy_q[C-1], oy_q} + {lsy_q[C-1], lsy_q};
      qx = {ox_q[C-1], ox_q} + {lex_q[C-1], lex_q};
      qy = {oy_q[C-1], oy_q} + {ley_q[C-1], ley_q};
    end
    dx   = {qx[C], qx} - {px[C], px};
    dy   = {qy[C], qy} - {py[C], py};
    magx = dx[C+1] ? MW'(-dx) : MW'(dx);
    magy = dy[C+1] ? MW'(-dy) : MW'(dy);
  end

  // ---------------- pipeline control: every stage advances together
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic v1_q, v2_q, v3_q, v4_q;
  logic vdiv_q [MW];
  logic hdiv_q [MW];

  // ---------------- stage 1: probe differences
  logic signed [C-1:0] sx, sy, ex, ey;
  assign sx = s_axis_tdata[C-1:0];
  assign sy = s_axis_tdata[2*C-1:C];
  assign ex = s_axis_tdata[3*C-1:2*C];
  assign ey = s_axis_tdata[4*C-1:3*C];

  logic signed [C:0]   fx_q, fy_q;
  logic signed [C+1:0] wx_q, wy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      fx_q <= {ex[C-1], ex} - {sx[C-1], sx};
      fy_q <= {ey[C-1], ey} - {sy[C-1], sy};
      wx_q <= {sx[C-1], sx[C-1], sx} - {px[C], px};
      wy_q <= {sy[C-1], sy[C-1], sy} - {py[C], py};
    end
  end

  // ---------------- stage 2: six products
  logic signed [PW-1:0] p_dfy_q, p_dyfx_q, p_wxfy_q, p_wyfx_q, p_wxdy_q, p_wydx_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_dfy_q  <= PW'(dx * fy_q);
      p_dyfx_q <= PW'(dy * fx_q);
      p_wxfy_q <= PW'(wx_q * fy_q);
      p_wyfx_q <= PW'(wy_q * fx_q);
      p_wxdy_q <= PW'(wx_q * dy);
      p_wydx_q <= PW'(wy_q * dx);
    end
  end

  // ---------------- stage 3: determinants
  logic signed [SW-1:0] den3_q, tn3_q, un3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      den3_q <= {p_dfy_q[PW-1], p_dfy_q} - {p_dyfx_q[PW-1], p_dyfx_q};
      tn3_q  <= {p_wxfy_q[PW-1], p_wxfy_q} - {p_wyfx_q[PW-1], p_wyfx_q};
      un3_q  <= {p_wxdy_q[PW-1], p_wxdy_q} - {p_wydx_q[PW-1], p_wydx_q};
    end
  end

  // ---------------- stage 4: sign normalisation and range test
  logic signed [SW-1:0] den_n, tn_n, un_n;
  logic                 hit4_d, hit4_q;
  logic [UW-1:0]        den4_q, tn4_q;

  always_comb begin
    if (den3_q < 0) begin
      den_n = -den3_q; tn_n = -tn3_q; un_n = -un3_q;
    end else begin
      den_n = den3_q; tn_n = tn3_q; un_n = un3_q;
    end
    hit4_d = (den3_q != '0) && (tn_n >= 0) && (un_n >= 0) &&
             (tn_n <= den_n) && (un_n <= den_n);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit4_q <= hit4_d;
      den4_q <= hit4_d ? den_n[UW-1:0] : UW'(1);
      tn4_q  <= hit4_d ? tn_n[UW-1:0]  : '0;
    end
  end

  // ---------------- quotient pipelines, one per axis
  logic [MW:0] qx_r, qy_r;

  sit_muldiv #(.CoordBits(C)) u_div_x (
    .clk_i (clk_i), .en_i (en), .mag_i (magx),
    .b_i (tn4_q), .c_i (den4_q), .q_o (qx_r)
  );

  sit_muldiv #(.CoordBits(C)) u_div_y (
    .clk_i (clk_i), .en_i (en), .mag_i (magy),
    .b_i (tn4_q), .c_i (den4_q), .q_o (qy_r)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      hdiv_q[0] <= hit4_q;
      for (int k = 1; k < MW; k++) hdiv_q[k] <= hdiv_q[k-1];
    end
  end

  // ---------------- valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      for (int k = 0; k < MW; k++) vdiv_q[k] <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      vdiv_q[0] <= v4_q;
      for (int k = 1; k < MW; k++) vdiv_q[k] <= vdiv_q[k-1];
      m_axis_tvalid <= vdiv_q[MW-1];
    end
  end

  // ---------------- output: add line start, saturate
  localparam logic signed [C+2:0] SMAX = {4'b0000, {(C-1){1'b1}}};
  localparam logic signed [C+2:0] SMIN = {4'b1111, {(C-1){1'b0}}};

  logic signed [C+2:0] offx, offy, sumx, sumy;
  logic [C-1:0]        cx_d, cy_d;
  logic                hit_q;
  logic [C-1:0]        cx_q, cy_q;

  always_comb begin
    offx = dx[C+1] ? -$signed({1'b0, qx_r}) : $signed({1'b0, qx_r});
    offy = dy[C+1] ? -$signed({1'b0, qy_r}) : $signed({1'b0, qy_r});
    sumx = {{2{px[C]}}, px} + offx;
    sumy = {{2{py[C]}}, py} + offy;
    if (sumx > SMAX)      cx_d = SMAX[C-1:0];
    else if (sumx < SMIN) cx_d = SMIN[C-1:0];
    else                  cx_d = sumx[C-1:0];
    if (sumy > SMAX)      cy_d = SMAX[C-1:0];
    else if (sumy < SMIN) cy_d = SMIN[C-1:0];
    else                  cy_d = sumy[C-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= hdiv_q[MW-1];
      cx_q  <= hdiv_q[MW-1] ? cx_d : '0;
      cy_q  <= hdiv_q[MW-1] ? cy_d : '0;
    end
  end

  assign m_axis_tdata = {(OW-2*C-1)'(0), cy_q, cx_q, hit_q};

  // ---------------- assertions
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !hit_q |-> cx_q == '0 && cy_q == '0)
    else $error("miss with non-zero crossing point");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && hit4_q |-> den4_q != '0 && tn4_q <= den4_q)
    else $error("hit with parameter out of range");

endmodule
`default_nettype wire
